### rtl/core/tbp_pkg.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Shared widths, table defaults and 2-bit saturating counter helpers.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int PC_BITS = 32;
    localparam int CTR_BITS = 2;

    localparam int DEF_GLOBAL_INDEX_BITS = 12;
    localparam int DEF_HISTORY_BITS      = 10;
    localparam int DEF_LOCAL_INDEX_BITS  = 10;
    localparam int DEF_META_INDEX_BITS   = 12;
    localparam int DEF_HIST_TABLE_BITS   = 10;

    localparam logic [CTR_BITS-1:0] CTR_STRONG_NT = 2'd0;
    localparam logic [CTR_BITS-1:0] CTR_WEAK_T    = 2'd2;
    localparam logic [CTR_BITS-1:0] CTR_STRONG_T  = 2'd3;

    // A counter predicts taken in its upper half.
    function automatic logic ctr_taken(input logic [CTR_BITS-1:0] c);
        return c[CTR_BITS-1];
    endfunction

    function automatic logic [CTR_BITS-1:0] ctr_train(input logic [CTR_BITS-1:0] c,
                                                      input logic up);
        logic [CTR_BITS-1:0] r;
        r = c;
        if (up) begin
            if (c != CTR_STRONG_T) r = c + 2'd1;
        end else begin
            if (c != CTR_STRONG_NT) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

### rtl/core/tbp_if.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor channels
// Branch channel (pc, outcome) and prediction channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbp_br_if;
    logic                        valid;
    logic                        ready;
    logic [tbp_pkg::PC_BITS-1:0] pc;
    logic                        taken;

    modport source (output valid, output pc, output taken, input ready);
    modport sink   (input valid, input pc, input taken, output ready);
endinterface

interface tbp_pred_if;
    logic valid;
    logic ready;
    logic global_guess;
    logic local_guess;
    logic chose_local;
    logic hybrid_guess;
    logic hybrid_right;

    modport source (output valid, output global_guess, output local_guess,
                    output chose_local, output hybrid_guess, output hybrid_right,
                    input ready);
    modport sink   (input valid, input global_guess, input local_guess,
                    input chose_local, input hybrid_guess, input hybrid_right,
                    output ready);
endinterface

### rtl/core/tournament_branch_predictor.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Takes one resolved branch per transaction and returns the bimodal, local and
// chosen predictions made before training. The pipeline accepts one branch
// per cycle unless stalled and passes it through stage 1, stage 2 and the
// output register: the branch reads the bimodal, history and chooser tables,
// then the local counter table at the index given by its history, then trains
// all four tables. Updates still in flight are forwarded to later branches.
// After reset an initialisation pass over 2**max(index widths) addresses
// (4096 by default) loads the tables, during which no branch is accepted. A
// waiting result stalls the whole pipeline.
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
    parameter int GLOBAL_INDEX_BITS = tbp_pkg::DEF_GLOBAL_INDEX_BITS,
    parameter int HISTORY_BITS      = tbp_pkg::DEF_HISTORY_BITS,
    parameter int LOCAL_INDEX_BITS  = tbp_pkg::DEF_LOCAL_INDEX_BITS,
    parameter int META_INDEX_BITS   = tbp_pkg::DEF_META_INDEX_BITS,
    parameter int HIST_TABLE_BITS   = tbp_pkg::DEF_HIST_TABLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbp_br_if.sink      i_br,
    tbp_pred_if.source  o_pred
);

    localparam int GB = GLOBAL_INDEX_BITS;
    localparam int HB = HISTORY_BITS;
    localparam int LB = LOCAL_INDEX_BITS;
    localparam int MB = META_INDEX_BITS;
    localparam int TB = HIST_TABLE_BITS;
    localparam int CB = tbp_pkg::CTR_BITS;
    localparam int MAX_GT = (GB > TB) ? GB : TB;
    localparam int MAX_LM = (LB > MB) ? LB : MB;
    localparam int CLR_BITS = (MAX_GT > MAX_LM) ? MAX_GT : MAX_LM;

    // ------------------------------------------------------------------------
    // Initialisation and pipeline advance
    // ------------------------------------------------------------------------
    logic                w_clr_busy;
    logic [CLR_BITS-1:0] w_clr_addr;
    logic                w_adv;
    logic                w_accept;

    tbp_clear #(.ADDR_BITS(CLR_BITS)) u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (w_clr_busy),
        .o_addr  (w_clr_addr)
    );

    logic r_out_valid;

    // Every pipeline register, including the table read registers, moves only on advance.
    assign w_adv      = !r_out_valid || o_pred.ready;
    assign i_br.ready = w_adv && !w_clr_busy;
    assign w_accept   = i_br.valid && i_br.ready;

    // ------------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------------
    logic          r_s1_valid;
    logic [GB-1:0] r_s1_gi;
    logic [TB-1:0] r_s1_hi;
    logic [MB-1:0] r_s1_mi;
    logic          r_s1_taken;

    logic          r_s2_valid;
    logic [GB-1:0] r_s2_gi;
    logic [TB-1:0] r_s2_hi;
    logic [MB-1:0] r_s2_mi;
    logic [LB-1:0] r_s2_li;
    logic          r_s2_taken;
    logic [HB-1:0] r_s2_hist;
    logic [CB-1:0] r_s2_bim;
    logic [CB-1:0] r_s2_chs;

    // The last two committed updates, newest first.
    logic          r_wb1_valid;
    logic [GB-1:0] r_wb1_gi;
    logic [TB-1:0] r_wb1_hi;
    logic [MB-1:0] r_wb1_mi;
    logic [LB-1:0] r_wb1_li;
    logic [CB-1:0] r_wb1_bim;
    logic [CB-1:0] r_wb1_chs;
    logic [CB-1:0] r_wb1_loc;
    logic [HB-1:0] r_wb1_hist;

    logic          r_wb2_valid;
    logic [GB-1:0] r_wb2_gi;
    logic [MB-1:0] r_wb2_mi;
    logic [LB-1:0] r_wb2_li;
    logic [CB-1:0] r_wb2_bim;
    logic [CB-1:0] r_wb2_chs;
    logic [CB-1:0] r_wb2_loc;

    // ------------------------------------------------------------------------
    // Tables
    // ------------------------------------------------------------------------
    logic          w_we;
    logic [CB-1:0] w_bim_rdata;
    logic [HB-1:0] w_hist_rdata;
    logic [CB-1:0] w_chs_rdata;
    logic [CB-1:0] w_loc_rdata;

    logic [GB-1:0] w_bim_waddr;
    logic [TB-1:0] w_hist_waddr;
    logic [MB-1:0] w_chs_waddr;
    logic [LB-1:0] w_loc_waddr;
    logic [CB-1:0] w_bim_wdata;
    logic [HB-1:0] w_hist_wdata;
    logic [CB-1:0] w_chs_wdata;
    logic [CB-1:0] w_loc_wdata;

    logic [HB-1:0] w_s1_hist;
    logic [LB-1:0] w_s1_li;
    logic [CB-1:0] w_s2_bim;
    logic [CB-1:0] w_s2_chs;
    logic [CB-1:0] w_s2_loc;
    logic [CB-1:0] w_s2_bim_new;
    logic [CB-1:0] w_s2_chs_new;
    logic [CB-1:0] w_s2_loc_new;
    logic [HB-1:0] w_s2_hist_new;

    assign w_we = w_clr_busy || (w_adv && r_s2_valid);

    assign w_bim_waddr  = w_clr_busy ? w_clr_addr[GB-1:0] : r_s2_gi;
    assign w_hist_waddr = w_clr_busy ? w_clr_addr[TB-1:0] : r_s2_hi;
    assign w_chs_waddr  = w_clr_busy ? w_clr_addr[MB-1:0] : r_s2_mi;
    assign w_loc_waddr  = w_clr_busy ? w_clr_addr[LB-1:0] : r_s2_li;
    assign w_bim_wdata  = w_clr_busy ? tbp_pkg::CTR_WEAK_T : w_s2_bim_new;
    assign w_hist_wdata = w_clr_busy ? '0 : w_s2_hist_new;
    assign w_chs_wdata  = w_clr_busy ? tbp_pkg::CTR_WEAK_T : w_s2_chs_new;
    assign w_loc_wdata  = w_clr_busy ? tbp_pkg::CTR_WEAK_T : w_s2_loc_new;

    tbp_ram #(.DATA_BITS(CB), .ADDR_BITS(GB)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_bim_waddr),
        .i_wdata (w_bim_wdata),
        .i_re    (w_adv),
        .i_raddr (i_br.pc[GB-1:0]),
        .o_rdata (w_bim_rdata)
    );

    tbp_ram #(.DATA_BITS(HB), .ADDR_BITS(TB)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_re    (w_adv),
        .i_raddr (i_br.pc[TB-1:0]),
        .o_rdata (w_hist_rdata)
    );

    tbp_ram #(.DATA_BITS(CB), .ADDR_BITS(MB)) u_chs_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_chs_waddr),
        .i_wdata (w_chs_wdata),
        .i_re    (w_adv),
        .i_raddr (i_br.pc[MB-1:0]),
        .o_rdata (w_chs_rdata)
    );

    tbp_ram #(.DATA_BITS(CB), .ADDR_BITS(LB)) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_loc_waddr),
        .i_wdata (w_loc_wdata),
        .i_re    (w_adv),
        .i_raddr (w_s1_li),
        .o_rdata (w_loc_rdata)
    );

    // ------------------------------------------------------------------------
    // Stage 1: resolve the history, then index the local table
    // ------------------------------------------------------------------------
    // The history read missed the update committing alongside it (now in the
    // first write-back register) and the one being made in stage 2 right now.
    always_comb begin
        priority if (r_s2_valid && (r_s2_hi == r_s1_hi)) begin
            w_s1_hist = w_s2_hist_new;
        end else if (r_wb1_valid && (r_wb1_hi == r_s1_hi)) begin
            w_s1_hist = r_wb1_hist;
        end else begin
            w_s1_hist = w_hist_rdata;
        end
    end

    generate
        if (HB >= LB) begin : g_li_trunc
            assign w_s1_li = w_s1_hist[LB-1:0];
        end else begin : g_li_ext
            assign w_s1_li = {{(LB-HB){1'b0}}, w_s1_hist};
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Stage 2: predict and train
    // ------------------------------------------------------------------------
    always_comb begin
        priority if (r_wb1_valid && (r_wb1_gi == r_s2_gi)) begin
            w_s2_bim = r_wb1_bim;
        end else if (r_wb2_valid && (r_wb2_gi == r_s2_gi)) begin
            w_s2_bim = r_wb2_bim;
        end else begin
            w_s2_bim = r_s2_bim;
        end
    end

    always_comb begin
        priority if (r_wb1_valid && (r_wb1_mi == r_s2_mi)) begin
            w_s2_chs = r_wb1_chs;
        end else if (r_wb2_valid && (r_wb2_mi == r_s2_mi)) begin
            w_s2_chs = r_wb2_chs;
        end else begin
            w_s2_chs = r_s2_chs;
        end
    end

    always_comb begin
        priority if (r_wb1_valid && (r_wb1_li == r_s2_li)) begin
            w_s2_loc = r_wb1_loc;
        end else if (r_wb2_valid && (r_wb2_li == r_s2_li)) begin
            w_s2_loc = r_wb2_loc;
        end else begin
            w_s2_loc = w_loc_rdata;
        end
    end

    logic w_g_guess;
    logic w_l_guess;
    logic w_use_local;
    logic w_h_guess;
    logic w_g_ok;
    logic w_l_ok;

    assign w_g_guess   = tbp_pkg::ctr_taken(w_s2_bim);
    assign w_l_guess   = tbp_pkg::ctr_taken(w_s2_loc);
    assign w_use_local = tbp_pkg::ctr_taken(w_s2_chs);
    assign w_h_guess   = w_use_local ? w_l_guess : w_g_guess;
    assign w_g_ok      = (w_g_guess == r_s2_taken);
    assign w_l_ok      = (w_l_guess == r_s2_taken);

    // The chooser only moves when exactly one predictor was right.
    always_comb begin
        priority if (w_l_ok && !w_g_ok) begin
            w_s2_chs_new = tbp_pkg::ctr_train(w_s2_chs, 1'b1);
        end else if (w_g_ok && !w_l_ok) begin
            w_s2_chs_new = tbp_pkg::ctr_train(w_s2_chs, 1'b0);
        end else begin
            w_s2_chs_new = w_s2_chs;
        end
    end

    assign w_s2_bim_new = tbp_pkg::ctr_train(w_s2_bim, r_s2_taken);
    assign w_s2_loc_new = tbp_pkg::ctr_train(w_s2_loc, r_s2_taken);

    generate
        if (HB == 1) begin : g_hist_one
            assign w_s2_hist_new = r_s2_taken;
        end else begin : g_hist_shift
            assign w_s2_hist_new = {r_s2_hist[HB-2:0], r_s2_taken};
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic r_global_guess;
    logic r_local_guess;
    logic r_chose_local;
    logic r_hybrid_guess;
    logic r_hybrid_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_wb1_valid <= 1'b0;
            r_wb2_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_accept;
            r_s2_valid  <= r_s1_valid;
            r_wb1_valid <= r_s2_valid;
            r_wb2_valid <= r_wb1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_gi    <= i_br.pc[GB-1:0];
            r_s1_hi    <= i_br.pc[TB-1:0];
            r_s1_mi    <= i_br.pc[MB-1:0];
            r_s1_taken <= i_br.taken;

            r_s2_gi    <= r_s1_gi;
            r_s2_hi    <= r_s1_hi;
            r_s2_mi    <= r_s1_mi;
            r_s2_li    <= w_s1_li;
            r_s2_taken <= r_s1_taken;
            r_s2_hist  <= w_s1_hist;
            r_s2_bim   <= w_bim_rdata;
            r_s2_chs   <= w_chs_rdata;

            r_wb1_gi   <= r_s2_gi;
            r_wb1_hi   <= r_s2_hi;
            r_wb1_mi   <= r_s2_mi;
            r_wb1_li   <= r_s2_li;
            r_wb1_bim  <= w_s2_bim_new;
            r_wb1_chs  <= w_s2_chs_new;
            r_wb1_loc  <= w_s2_loc_new;
            r_wb1_hist <= w_s2_hist_new;

            r_wb2_gi   <= r_wb1_gi;
            r_wb2_mi   <= r_wb1_mi;
            r_wb2_li   <= r_wb1_li;
            r_wb2_bim  <= r_wb1_bim;
            r_wb2_chs  <= r_wb1_chs;
            r_wb2_loc  <= r_wb1_loc;

            r_global_guess <= w_g_guess;
            r_local_guess  <= w_l_guess;
            r_chose_local  <= w_use_local;
            r_hybrid_guess <= w_h_guess;
            r_hybrid_right <= (w_h_guess == r_s2_taken);
        end
    end

    assign o_pred.valid        = r_out_valid;
    assign o_pred.global_guess = r_global_guess;
    assign o_pred.local_guess  = r_local_guess;
    assign o_pred.chose_local  = r_chose_local;
    assign o_pred.hybrid_guess = r_hybrid_guess;
    assign o_pred.hybrid_right = r_hybrid_right;

endmodule

### rtl/core/tbp_ram.sv
// ----------------------------------------------------------------------------
// Predictor table RAM
// Simple dual-port synchronous RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int DATA_BITS = 2,
    parameter int ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // A read to the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tbp_clear.sv
// ----------------------------------------------------------------------------
// Table initialisation sequencer
// After reset, sweeps one address per cycle so that all tables can be loaded
// with their reset contents.
// ----------------------------------------------------------------------------
module tbp_clear #(
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    output logic                 o_busy,
    output logic [ADDR_BITS-1:0] o_addr
);

    logic                 r_busy;
    logic                 n_busy;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] n_addr;

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        if (r_busy) begin
            n_addr = r_addr + 1'b1;
            if (&r_addr) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule
